FILE: hdl/clock_buffer_frame_replacer_unit_assert.svh
// Assertion macros for the clock buffer frame replacer.
// Depends on nothing; included by the top level, which supplies clock and reset names.
`ifndef CLOCK_BUFFER_FRAME_REPLACER_UNIT_ASSERT_SVH
`define CLOCK_BUFFER_FRAME_REPLACER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CBFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CBFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CBFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CBFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/cbfr_pkg.sv
// Shared types, codes and sizes for the clock buffer frame replacer.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package cbfr_pkg;

  // Table geometry.
  localparam int FRAMES    = 8;
  localparam int PAGE_W    = 16;
  localparam int IDX_W     = $clog2(FRAMES);
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int STEP_W    = $clog2(2 * FRAMES);
  localparam int PIN_W     = 8;
  localparam int CFG_W     = 4;
  localparam int ACT_W     = 3;
  localparam int ST_W      = 3;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [PIN_W-1:0] PIN_MAX = '1;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(FRAMES);

  // Action codes of a request.
  localparam logic [ACT_W-1:0] ACT_REQUEST = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DIRTY   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAN   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PIN     = 3'd4;

  // Register index of the pool size.
  localparam logic [APB_AW-1:0] REG_FRAMES_IN_USE = 3'd0;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [PIN_W-1:0]  pin_t;

  typedef enum logic [ST_W-1:0] {
    ST_HIT          = 3'd0,
    ST_LOADED       = 3'd1,
    ST_REPLACED     = 3'd2,
    ST_ALL_PINNED   = 3'd3,
    ST_NO_VICTIM    = 3'd4,
    ST_NOT_RESIDENT = 3'd5,
    ST_DONE         = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EVAL  = 2'd1,
    S_SWEEP = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic eval;
    logic sweep;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_sweep;
    logic sweep_end;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/clock_buffer_frame_replacer_unit.sv
// A request is accepted when start is high and busy low; it is captured, evaluated in the
// evaluate state, and its result is registered and shown after that state, or after the clock
// sweep when the sweep visits k frames (1 <= k <= 2 * pool size).
// No new request is taken while busy; the next request is taken in the cycle its
// predecessor's result is shown. The receiver cannot stall. Reset (rst_n low, synchronous)
// clears frame flags, pin counts, the hand and the strobe, and sets the pool size to eight.
`default_nettype none

`include "clock_buffer_frame_replacer_unit_assert.svh"

module clock_buffer_frame_replacer_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [cbfr_pkg::ACT_W-1:0]         in_action,
  input  wire logic [cbfr_pkg::PAGE_W-1:0]        in_page_id,
  output logic                                    out_valid,
  output logic [cbfr_pkg::ST_W-1:0]               out_status,
  output logic [cbfr_pkg::IDX_W-1:0]              out_frame_index,
  output logic [cbfr_pkg::PAGE_W-1:0]             out_evicted_page,
  output logic [cbfr_pkg::PIN_W-1:0]              out_pin_count_after,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [cbfr_pkg::APB_AW-1:0]        paddr,
  input  wire logic [cbfr_pkg::APB_DW-1:0]        pwdata,
  output logic [cbfr_pkg::APB_DW-1:0]             prdata,
  output logic                                    pready
);

  cbfr_pkg::dp_cmd_t  cmd;
  cbfr_pkg::dp_stat_t stat;

  logic [cbfr_pkg::CFG_W-1:0] frames_in_use_r, frames_in_use_nxt;
  logic                       cfg_wr;

  // Register port: one register at word zero, writes complete in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[cbfr_pkg::APB_AW-1:2] == cbfr_pkg::REG_FRAMES_IN_USE[cbfr_pkg::APB_AW-1:2]);

  always_comb begin
    frames_in_use_nxt = frames_in_use_r;
    if (cfg_wr) frames_in_use_nxt = pwdata[cbfr_pkg::CFG_W-1:0];
  end

  always_comb begin
    prdata = '0;
    if (paddr[cbfr_pkg::APB_AW-1:2] == cbfr_pkg::REG_FRAMES_IN_USE[cbfr_pkg::APB_AW-1:2]) begin
      prdata = {{(cbfr_pkg::APB_DW - cbfr_pkg::CFG_W){1'b0}}, frames_in_use_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= cbfr_pkg::CFG_RESET;
    end else begin
      frames_in_use_r <= frames_in_use_nxt;
    end
  end

  cbfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cbfr_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .frames_in_use       (frames_in_use_r),
    .in_action           (in_action),
    .in_page_id          (in_page_id),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_frame_index     (out_frame_index),
    .out_evicted_page    (out_evicted_page),
    .out_pin_count_after (out_pin_count_after)
  );

  // Results are never back to back: every request needs an evaluate cycle.
  `CBFR_ASSERT_NXT(a_strobe_gap, clk, rst_n, out_valid, !out_valid, "result strobe repeated")

  // An accepted request makes the block busy in the next cycle.
  `CBFR_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted request not busy")

  // Results without a frame carry all-zero fields.
  `CBFR_ASSERT_IMP(a_no_frame_zero, clk, rst_n,
    out_valid && (out_status == cbfr_pkg::ST_ALL_PINNED ||
                  out_status == cbfr_pkg::ST_NO_VICTIM ||
                  out_status == cbfr_pkg::ST_NOT_RESIDENT),
    out_frame_index == '0 && out_evicted_page == '0 && out_pin_count_after == '0,
    "frameless result has nonzero fields")

  // A fresh load or replacement always leaves exactly one pin.
  `CBFR_ASSERT_IMP(a_load_pin, clk, rst_n,
    out_valid && (out_status == cbfr_pkg::ST_LOADED || out_status == cbfr_pkg::ST_REPLACED),
    out_pin_count_after == cbfr_pkg::pin_t'(1),
    "loaded frame pin count is not one")

endmodule

`default_nettype wire

FILE: hdl/cbfr_ctrl.sv
// Controller state machine of the frame replacer: idle, evaluate, clock sweep.
// Depends on cbfr_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module cbfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire cbfr_pkg::dp_stat_t stat,
  output cbfr_pkg::dp_cmd_t      cmd,
  output logic                   busy
);

  cbfr_pkg::state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbfr_pkg::S_IDLE: begin
        if (start) state_nxt = cbfr_pkg::S_EVAL;
      end
      cbfr_pkg::S_EVAL: begin
        state_nxt = stat.go_sweep ? cbfr_pkg::S_SWEEP : cbfr_pkg::S_IDLE;
      end
      cbfr_pkg::S_SWEEP: begin
        if (stat.sweep_end) state_nxt = cbfr_pkg::S_IDLE;
      end
      default: state_nxt = cbfr_pkg::S_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      cbfr_pkg::S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      cbfr_pkg::S_EVAL:  cmd.eval  = 1'b1;
      cbfr_pkg::S_SWEEP: cmd.sweep = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbfr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cbfr_dp.sv
// Datapath of the frame replacer: frame table, clock hand, sweep counter, result registers.
// Depends on cbfr_pkg; commanded by cbfr_ctrl.
`default_nettype none

module cbfr_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cbfr_pkg::dp_cmd_t            cmd,
  output cbfr_pkg::dp_stat_t                stat,
  input  wire logic [cbfr_pkg::CFG_W-1:0]   frames_in_use,
  input  wire logic [cbfr_pkg::ACT_W-1:0]   in_action,
  input  wire logic [cbfr_pkg::PAGE_W-1:0]  in_page_id,
  output logic                              out_valid,
  output logic [cbfr_pkg::ST_W-1:0]         out_status,
  output logic [cbfr_pkg::IDX_W-1:0]        out_frame_index,
  output logic [cbfr_pkg::PAGE_W-1:0]       out_evicted_page,
  output logic [cbfr_pkg::PIN_W-1:0]        out_pin_count_after
);

  localparam int FRAMES = cbfr_pkg::FRAMES;
  localparam int IDX_W  = cbfr_pkg::IDX_W;
  localparam int CNT_W  = cbfr_pkg::CNT_W;
  localparam int STEP_W = cbfr_pkg::STEP_W;

  // Captured request.
  logic [cbfr_pkg::ACT_W-1:0] act_r;
  cbfr_pkg::page_t            page_r;

  // Frame table.
  cbfr_pkg::page_t frame_page_r  [FRAMES];
  cbfr_pkg::page_t frame_page_nxt[FRAMES];
  cbfr_pkg::pin_t  pins_r  [FRAMES];
  cbfr_pkg::pin_t  pins_nxt[FRAMES];
  logic [FRAMES-1:0] valid_r, valid_nxt;
  logic [FRAMES-1:0] ref_r, ref_nxt;
  logic [FRAMES-1:0] dirty_r, dirty_nxt;
  logic [FRAMES-1:0] lock_r, lock_nxt;

  cbfr_pkg::idx_t    hand_r, hand_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Result registers.
  logic                       out_valid_r, out_valid_nxt;
  cbfr_pkg::status_t          out_status_r, out_status_nxt;
  cbfr_pkg::idx_t             out_frame_r, out_frame_nxt;
  cbfr_pkg::page_t            out_evict_r, out_evict_nxt;
  cbfr_pkg::pin_t             out_pin_r, out_pin_nxt;

  // Lookup results.
  logic [CNT_W-1:0]  pool_n;
  logic [FRAMES-1:0] managed, hit_vec, empty_vec, free_vec;
  logic              hit_any, empty_any, free_any;
  cbfr_pkg::idx_t    hit_idx, empty_idx, hand_norm;
  logic [STEP_W-1:0] step_last;
  logic              victim;

  // Hand advance, wrapping at the pool size.
  function automatic cbfr_pkg::idx_t next_hand(cbfr_pkg::idx_t f, logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] fp1;
    fp1 = CNT_W'(f) + CNT_W'(1);
    return (fp1 == n) ? '0 : cbfr_pkg::idx_t'(f + IDX_W'(1));
  endfunction

  // Effective pool size: zero acts as one, oversize acts as the full table.
  always_comb begin
    if (frames_in_use == '0) begin
      pool_n = CNT_W'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      pool_n = CNT_W'(FRAMES);
    end else begin
      pool_n = CNT_W'(frames_in_use);
    end
  end

  // Parallel match, empty and free flags over the managed frames.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      managed[i]   = CNT_W'(i) < pool_n;
      hit_vec[i]   = managed[i] && valid_r[i] && (frame_page_r[i] == page_r);
      empty_vec[i] = managed[i] && !valid_r[i];
      free_vec[i]  = managed[i] && (pins_r[i] == '0);
    end
    hit_any   = |hit_vec;
    empty_any = |empty_vec;
    free_any  = |free_vec;
  end

  // Lowest index wins for both the hit and the empty frame.
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i])   hit_idx   = IDX_W'(i);
      if (empty_vec[i]) empty_idx = IDX_W'(i);
    end
  end

  assign hand_norm = (CNT_W'(hand_r) >= pool_n) ? '0 : hand_r;
  assign step_last = STEP_W'({pool_n, 1'b0} - 1);
  assign victim    = !lock_r[hand_r] && !ref_r[hand_r] && (pins_r[hand_r] == '0) &&
                     !dirty_r[hand_r];

  // Status toward the controller.
  always_comb begin
    stat.go_sweep  = (act_r == cbfr_pkg::ACT_REQUEST) && !hit_any && !empty_any && free_any;
    stat.sweep_end = victim || (step_r == step_last);
  end

  // Next-state logic of the table and the result.
  always_comb begin
    frame_page_nxt = frame_page_r;
    pins_nxt       = pins_r;
    valid_nxt      = valid_r;
    ref_nxt        = ref_r;
    dirty_nxt      = dirty_r;
    lock_nxt       = lock_r;
    hand_nxt       = hand_r;
    step_nxt       = step_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    out_evict_nxt  = out_evict_r;
    out_pin_nxt    = out_pin_r;

    if (cmd.eval) begin
      hand_nxt       = hand_norm;
      out_valid_nxt  = 1'b1;
      out_frame_nxt  = '0;
      out_evict_nxt  = '0;
      out_pin_nxt    = '0;
      out_status_nxt = cbfr_pkg::ST_DONE;
      case (act_r) inside
        cbfr_pkg::ACT_REQUEST: begin
          if (hit_any) begin
            if (pins_r[hit_idx] != cbfr_pkg::PIN_MAX) begin
              pins_nxt[hit_idx] = pins_r[hit_idx] + 1'b1;
            end
            ref_nxt[hit_idx] = 1'b1;
            out_status_nxt   = cbfr_pkg::ST_HIT;
            out_frame_nxt    = hit_idx;
            out_pin_nxt      = pins_nxt[hit_idx];
          end else if (empty_any) begin
            frame_page_nxt[empty_idx] = page_r;
            valid_nxt[empty_idx]      = 1'b1;
            pins_nxt[empty_idx]       = cbfr_pkg::pin_t'(1);
            ref_nxt[empty_idx]        = 1'b1;
            dirty_nxt[empty_idx]      = 1'b0;
            lock_nxt[empty_idx]       = 1'b0;
            hand_nxt                  = next_hand(empty_idx, pool_n);
            out_status_nxt            = cbfr_pkg::ST_LOADED;
            out_frame_nxt             = empty_idx;
            out_pin_nxt               = cbfr_pkg::pin_t'(1);
          end else if (!free_any) begin
            out_status_nxt = cbfr_pkg::ST_ALL_PINNED;
          end else begin
            // The clock sweep produces the result.
            out_valid_nxt = 1'b0;
            step_nxt      = '0;
          end
        end
        cbfr_pkg::ACT_RELEASE, cbfr_pkg::ACT_DIRTY, cbfr_pkg::ACT_CLEAN,
        cbfr_pkg::ACT_PIN: begin
          if (!hit_any) begin
            out_status_nxt = cbfr_pkg::ST_NOT_RESIDENT;
          end else begin
            if (act_r == cbfr_pkg::ACT_RELEASE && pins_r[hit_idx] != '0) begin
              pins_nxt[hit_idx] = pins_r[hit_idx] - 1'b1;
            end
            if (act_r == cbfr_pkg::ACT_DIRTY) dirty_nxt[hit_idx] = 1'b1;
            if (act_r == cbfr_pkg::ACT_CLEAN) dirty_nxt[hit_idx] = 1'b0;
            if (act_r == cbfr_pkg::ACT_PIN)   lock_nxt[hit_idx]  = 1'b1;
            out_frame_nxt = hit_idx;
            out_pin_nxt   = pins_nxt[hit_idx];
          end
        end
        default: out_status_nxt = cbfr_pkg::ST_DONE;
      endcase
    end else if (cmd.sweep) begin
      // One frame per cycle under the hand.
      hand_nxt = next_hand(hand_r, pool_n);
      if (victim) begin
        frame_page_nxt[hand_r] = page_r;
        valid_nxt[hand_r]      = 1'b1;
        pins_nxt[hand_r]       = cbfr_pkg::pin_t'(1);
        ref_nxt[hand_r]        = 1'b1;
        dirty_nxt[hand_r]      = 1'b0;
        lock_nxt[hand_r]       = 1'b0;
        out_valid_nxt          = 1'b1;
        out_status_nxt         = cbfr_pkg::ST_REPLACED;
        out_frame_nxt          = hand_r;
        out_evict_nxt          = frame_page_r[hand_r];
        out_pin_nxt            = cbfr_pkg::pin_t'(1);
      end else begin
        if (!lock_r[hand_r]) ref_nxt[hand_r] = 1'b0;
        step_nxt = step_r + 1'b1;
        if (step_r == step_last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cbfr_pkg::ST_NO_VICTIM;
          out_frame_nxt  = '0;
          out_evict_nxt  = '0;
          out_pin_nxt    = '0;
        end
      end
    end
  end

  // Control state and flags of the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      ref_r       <= '0;
      dirty_r     <= '0;
      lock_r      <= '0;
      hand_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAMES; i++) pins_r[i] <= '0;
    end else begin
      valid_r     <= valid_nxt;
      ref_r       <= ref_nxt;
      dirty_r     <= dirty_nxt;
      lock_r      <= lock_nxt;
      hand_r      <= hand_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      pins_r      <= pins_nxt;
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_action;
      page_r <= in_page_id;
    end
    frame_page_r <= frame_page_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
    out_evict_r  <= out_evict_nxt;
    out_pin_r    <= out_pin_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_frame_index     = out_frame_r;
  assign out_evicted_page    = out_evict_r;
  assign out_pin_count_after = out_pin_r;

endmodule

`default_nettype wire
